// ----- rtl/pcbp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the prefix code bit packer.
// Holds the command and result codes, default sizes and the control struct between stages.
package pcbp_pkg;

	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int SYMBOL_COUNT_DEF = 256;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_FINAL  = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_NOCODE = 2'd3
	} kind_t;

	typedef struct packed {
		logic flush;
		logic hit;
	} pcbp_ctrl_t;

endpackage

// ----- rtl/pcbp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the code table.
module pcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/pcbp_lookup.sv -----
`timescale 1ns / 1ps
// Input stage: takes items, writes the code table on loads and looks codes up on encodes.
// Depends on pcbp_pkg and pcbp_ram.
module pcbp_lookup import pcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           command,
	input  logic [7:0]                           symbol,
	input  logic [31:0]                          code_bits,
	input  logic [5:0]                           code_length,
	input  logic                                 take,
	output logic                                 s1_valid,
	output pcbp_ctrl_t                           s1_ctrl,
	output logic [((MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32)-1:0] s1_word,
	output logic [$clog2(MAX_CODE_LEN + 1)-1:0] s1_len
);

	localparam int WORD_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
	localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

	cmd_t                    cmd;
	logic                    accept;
	logic                    in_range;
	logic [ADDR_W-1:0]       addr;
	logic [LEN_W-1:0]        len_sat;
	logic [WORD_W:0]         one_sh;
	logic [WORD_W-1:0]       word_mask;
	logic                    ram_we;
	logic [LEN_W+WORD_W-1:0] ram_rdata;
	logic [SYMBOL_COUNT-1:0] entry_valid_q;
	logic                    s1_valid_q;
	pcbp_ctrl_t              s1_ctrl_s1;

	assign cmd      = cmd_t'(command);
	assign in_stall = s1_valid_q && !take;
	assign accept   = in_valid && !in_stall;
	assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
	assign addr     = symbol[ADDR_W-1:0];
	assign ram_we   = accept && (cmd == CMD_LOAD) && in_range;

	always_comb begin
		if (code_length > 6'(MAX_CODE_LEN)) begin
			len_sat = LEN_W'(MAX_CODE_LEN);
		end else begin
			len_sat = LEN_W'(code_length);
		end
		one_sh    = (WORD_W + 1)'(1) << len_sat;
		word_mask = WORD_W'(one_sh - (WORD_W + 1)'(1));
	end

	pcbp_ram #(
		.WIDTH(LEN_W + WORD_W),
		.DEPTH(SYMBOL_COUNT)
	) u_code_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata({len_sat, code_bits[WORD_W-1:0] & word_mask}),
		.re   (accept),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			s1_valid_q    <= 1'b0;
		end else begin
			if (ram_we) begin
				entry_valid_q[addr] <= (code_length != 6'd0);
			end
			if (!s1_valid_q || take) begin
				s1_valid_q <= accept && ((cmd == CMD_ENCODE) || (cmd == CMD_FLUSH));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_ctrl_s1.flush <= (cmd == CMD_FLUSH);
			s1_ctrl_s1.hit   <= in_range && entry_valid_q[addr];
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_ctrl  = s1_ctrl_s1;
	assign s1_word  = ram_rdata[WORD_W-1:0];
	assign s1_len   = ram_rdata[WORD_W +: LEN_W];

endmodule

// ----- rtl/pcbp_packer.sv -----
`timescale 1ns / 1ps
// Packing stage: appends looked-up codes to the pending bits and sends out one byte per cycle while out_stall is low.
// Depends on pcbp_pkg.
module pcbp_packer import pcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s1_valid,
	input  pcbp_ctrl_t                           s1_ctrl,
	input  logic [((MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32)-1:0] s1_word,
	input  logic [$clog2(MAX_CODE_LEN + 1)-1:0] s1_len,
	output logic                                 take,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           out_byte,
	output logic [1:0]                           kind,
	output logic [2:0]                           padding_bits,
	output logic                                 last_of_run
);

	localparam int WORD_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int BUF_W  = MAX_CODE_LEN + 7;
	localparam int TOT_W  = $clog2(MAX_CODE_LEN + 8);
	localparam int NB_W   = TOT_W - 3;

	logic              out_load;
	logic              emit_buf;
	logic              emit_new;
	logic              enc_hit;
	logic [TOT_W-1:0]  total;
	logic [NB_W-1:0]   nb;
	logic [2:0]        rem;
	logic [TOT_W-1:0]  shamt;
	logic [6:0]        pend_al;
	logic [BUF_W-1:0]  aligned;
	logic [6:0]        pend_sh;
	logic [6:0]        rem_mask;
	logic [6:0]        new_pend;
	logic [7:0]        nxt_byte;
	kind_t             nxt_kind;
	logic [2:0]        nxt_pad;
	logic              nxt_last;

	logic              out_valid_q;
	logic [NB_W-1:0]   left_q;
	logic [6:0]        pend_q;
	logic [2:0]        pcnt_q;
	logic [BUF_W-1:0]  buf_q;
	logic [7:0]        out_byte_q;
	kind_t             kind_q;
	logic [2:0]        pad_q;
	logic              last_q;

	always_comb begin
		out_load = !out_valid_q || !out_stall;
		take     = s1_valid && out_load && (left_q == '0);
		enc_hit  = !s1_ctrl.flush && s1_ctrl.hit;
		total    = TOT_W'(pcnt_q) + TOT_W'(s1_len);
		nb       = NB_W'(total >> 3);
		rem      = total[2:0];
		shamt    = TOT_W'(BUF_W) - total;
		pend_al  = pend_q << (3'd7 - pcnt_q);
		aligned  = {pend_al, {(BUF_W - 7){1'b0}}} | (BUF_W'(s1_word) << shamt);
		pend_sh  = 7'({7'b0, pend_q} << s1_len);
		rem_mask = 7'((8'd1 << rem) - 8'd1);
		new_pend = (pend_sh | 7'(s1_word)) & rem_mask;
		emit_buf = out_load && (left_q != '0);
		emit_new = take && (s1_ctrl.flush || !s1_ctrl.hit || (nb != '0));
	end

	always_comb begin
		nxt_byte = 8'd0;
		nxt_kind = KIND_BYTE;
		nxt_pad  = 3'd0;
		nxt_last = 1'b1;
		if (emit_buf) begin
			nxt_byte = buf_q[BUF_W-1 -: 8];
			nxt_last = (left_q == NB_W'(1));
		end else if (s1_ctrl.flush) begin
			if (pcnt_q != 3'd0) begin
				nxt_byte = {pend_al, 1'b0};
				nxt_kind = KIND_FINAL;
				nxt_pad  = 3'(4'd8 - {1'b0, pcnt_q});
			end else begin
				nxt_kind = KIND_EMPTY;
			end
		end else if (!s1_ctrl.hit) begin
			nxt_kind = KIND_NOCODE;
		end else begin
			nxt_byte = aligned[BUF_W-1 -: 8];
			nxt_last = (nb == NB_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			left_q      <= '0;
			pend_q      <= 7'd0;
			pcnt_q      <= 3'd0;
		end else begin
			if (out_load) begin
				out_valid_q <= emit_buf || emit_new;
			end
			if (emit_buf) begin
				left_q <= left_q - NB_W'(1);
			end else if (take && enc_hit && (nb != '0)) begin
				left_q <= nb - NB_W'(1);
			end
			if (take && s1_ctrl.flush) begin
				pend_q <= 7'd0;
				pcnt_q <= 3'd0;
			end else if (take && enc_hit) begin
				pend_q <= new_pend;
				pcnt_q <= rem;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_buf || emit_new) begin
			out_byte_q <= nxt_byte;
			kind_q     <= nxt_kind;
			pad_q      <= nxt_pad;
			last_q     <= nxt_last;
		end
		if (emit_buf) begin
			buf_q <= buf_q << 8;
		end else if (take && enc_hit) begin
			buf_q <= aligned << 8;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign kind         = kind_q;
	assign padding_bits = pad_q;
	assign last_of_run  = last_q;

endmodule

// ----- rtl/prefix_code_bit_packer.sv -----
`timescale 1ns / 1ps
// Prefix code bit packer: a loaded table of prefix codes packed into bytes, MSB first.
// The lookup stage registers an accepted item, and the packer registers its first result in the output register.
// Throughput: one item per cycle while the output is not stalled, except that an encode giving n bytes holds the
// output register until all n are sent (up to (MAX_CODE_LEN + 7) / 8, so four at the default length).
// Reset clears the valid marks, the pending bits and the pipeline; table words are undefined.
module prefix_code_bit_packer import pcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  symbol,
	input  logic [31:0] code_bits,
	input  logic [5:0]  code_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  kind,
	output logic [2:0]  padding_bits,
	output logic        last_of_run
);

	localparam int WORD_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);

	logic              take;
	logic              s1_valid;
	pcbp_ctrl_t        s1_ctrl;
	logic [WORD_W-1:0] s1_word;
	logic [LEN_W-1:0]  s1_len;

	pcbp_lookup #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.symbol     (symbol),
		.code_bits  (code_bits),
		.code_length(code_length),
		.take       (take),
		.s1_valid   (s1_valid),
		.s1_ctrl    (s1_ctrl),
		.s1_word    (s1_word),
		.s1_len     (s1_len)
	);

	pcbp_packer #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1_valid    (s1_valid),
		.s1_ctrl     (s1_ctrl),
		.s1_word     (s1_word),
		.s1_len      (s1_len),
		.take        (take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.kind        (kind),
		.padding_bits(padding_bits),
		.last_of_run (last_of_run)
	);

	// A stalled result must block the packer from taking the next item.
	a_stall_blocks_take: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !take)
		else $error("packer took an item while the output was stalled");

	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> s1_valid)
		else $error("packer took an item from an empty stage");

	a_pad_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind != KIND_FINAL)) |-> (padding_bits == 3'd0))
		else $error("padding count on a result that is not a final byte");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((kind == KIND_EMPTY) || (kind == KIND_NOCODE)))
			|-> (last_of_run && (out_byte == 8'd0)))
		else $error("status result is not a lone zero item");

endmodule
